// ===== rtl/fcol_pkg.sv =====
// Package for the fixed-capacity ordered list: field widths, command codes
// and the result record shared by the controller, the interfaces and the top level.
// Depends on nothing.
`timescale 1ns / 1ps

package fcol_pkg;

  localparam int DEF_CAPACITY = 128;
  localparam int ELEM_W       = 32;
  localparam int POS_W        = 8;
  localparam int IDX_W        = 7;
  localparam int CNT_W        = 8;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic             status;
    logic             found;
    logic [IDX_W-1:0] found_index;
    logic [CNT_W-1:0] entry_count;
    logic             is_empty;
    logic             is_full;
  } result_t;

endpackage

// ===== rtl/fcol_req_if.sv =====
// Request channel of the ordered list: valid/ready handshake with command,
// element and position. Depends on fcol_pkg.
`timescale 1ns / 1ps

interface fcol_req_if;
  import fcol_pkg::*;

  logic                     valid;
  logic                     ready;
  cmd_t                     command;
  logic signed [ELEM_W-1:0] element;
  logic [POS_W-1:0]         position;

  modport source (output valid, command, element, position, input ready);
  modport sink   (input valid, command, element, position, output ready);
endinterface

// ===== rtl/fcol_rsp_if.sv =====
// Result channel of the ordered list: valid/ready handshake with status,
// search outcome and list occupancy. Depends on fcol_pkg.
`timescale 1ns / 1ps

interface fcol_rsp_if;
  import fcol_pkg::*;

  logic             valid;
  logic             ready;
  logic             status;
  logic             found;
  logic [IDX_W-1:0] found_index;
  logic [CNT_W-1:0] entry_count;
  logic             is_empty;
  logic             is_full;

  modport source (output valid, status, found, found_index, entry_count, is_empty, is_full,
                  input ready);
  modport sink   (input valid, status, found, found_index, entry_count, is_empty, is_full,
                  output ready);
endinterface

// ===== rtl/fixed_capacity_ordered_list.sv =====
// Fixed-capacity ordered list of signed 32-bit values, top level.
// Holds the sequencer, the entry RAM and the result register. Depends on
// fcol_pkg, fcol_req_if, fcol_rsp_if, fcol_ram and fcol_ctrl.
`timescale 1ns / 1ps

// The block keeps up to CAPACITY signed 32-bit entries in one RAM with
// registered read data, and the entry count in a register. Every request
// carries one command (append, insert at a position, search for a value,
// delete at a position) and yields exactly one result, which reports success
// or error, the search outcome and the count, empty and full flags after the
// command. Requests are handled one at a time, and the block is ready for a
// new request only when the previous one has left the sequencer. An append,
// an insert at the end of the list, a rejected command, a delete of the
// last entry and a search of an empty list pass from acceptance straight
// to the result state. An insert at position p moves count - p entries
// and then writes the new value at p; a delete at position p moves
// count - p - 1 entries; a search of a non-empty list reads from index 0
// upward and stops at the first hit or after the last entry. Moves and
// searches use the single RAM read port, which streams one entry per
// cycle while the write port stores each moved entry in the cycle after
// it is read. The result register lets a finished result wait for the
// consumer while the next request is accepted; the sequencer only holds
// back when a new result is ready and the previous one has not yet been
// taken. Entries are never cleared: only entries below the count are
// ever read, and those have always been written.

module fixed_capacity_ordered_list #(
  parameter int CAPACITY = fcol_pkg::DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst,
  fcol_req_if.sink   req,
  fcol_rsp_if.source rsp
);
  import fcol_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              done;
  logic              slot_free;
  result_t           res;
  result_t           res_q;
  logic              res_valid;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [ELEM_W-1:0] mem_rdata;

  fcol_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .slot_free (slot_free),
    .done      (done),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  fcol_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The result register is free when empty or when its content leaves now.
  assign slot_free = !res_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (done) begin
      res_valid <= 1'b1;
    end else if (rsp.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      res_q <= res;
    end
  end

  assign rsp.valid       = res_valid;
  assign rsp.status      = res_q.status;
  assign rsp.found       = res_q.found;
  assign rsp.found_index = res_q.found_index;
  assign rsp.entry_count = res_q.entry_count;
  assign rsp.is_empty    = res_q.is_empty;
  assign rsp.is_full     = res_q.is_full;

  // A result must never overwrite one that the consumer has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    done |-> (!res_valid || rsp.ready))
    else $error("result register overwritten while still pending");

  // Every accepted request keeps the sequencer busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still in progress");

  // RAM writes stay inside the list capacity.
  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (32'(mem_waddr) < CAPACITY))
    else $error("entry RAM written beyond capacity");

  // A reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (32'(res.entry_count) <= CAPACITY))
    else $error("entry count above capacity");

endmodule

// ===== rtl/fcol_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered
// read data. Depends on nothing.
`timescale 1ns / 1ps

module fcol_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 128,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/fcol_ctrl.sv =====
// Command sequencer of the ordered list: holds the entry count and walks the
// entry RAM for shifts and searches. Depends on fcol_pkg and fcol_req_if.
`timescale 1ns / 1ps

module fcol_ctrl #(
  parameter int  CAPACITY = fcol_pkg::DEF_CAPACITY,
  localparam int AW       = $clog2(CAPACITY),
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  fcol_req_if.sink                      req,
  input  logic                          slot_free,
  output logic                          done,
  output fcol_pkg::result_t             res,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [fcol_pkg::ELEM_W-1:0]   mem_wdata,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [fcol_pkg::ELEM_W-1:0]   mem_rdata
);
  import fcol_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RUN  = 5'b00010,
    S_TAIL = 5'b00100,
    S_PUT  = 5'b01000,
    S_RESP = 5'b10000
  } state_t;

  state_t            state;
  cmd_t              cmd;
  logic [ELEM_W-1:0] val;
  logic [POS_W-1:0]  pos;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     ra;
  logic [AW-1:0]     pa;
  logic              pv;
  logic              err;
  logic              hit;
  logic [AW-1:0]     hidx;

  logic              acc;
  logic              full;
  logic [CW-1:0]     cnt_m1;
  logic [CNT_W-1:0]  cnt_ext;
  logic [POS_W-1:0]  pos_in;
  logic              last_rd;
  logic              match;
  logic [AW-1:0]     pa_next;

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign pos_in    = req.position;
  assign full      = (cnt == CW'(CAPACITY));
  assign cnt_m1    = cnt - CW'(1);
  assign cnt_ext   = CNT_W'(cnt);
  assign match     = (mem_rdata == val);
  assign last_rd   = (cmd == CMD_INSERT) ? (ra == pos[AW-1:0]) : (ra == cnt_m1[AW-1:0]);

  always_comb begin
    case (cmd)
      CMD_INSERT: pa_next = ra + AW'(1);
      CMD_DELETE: pa_next = ra - AW'(1);
      default:    pa_next = ra;
    endcase
  end

  // RAM port: direct writes for append and insert at the end, the delayed
  // half of each shift move, and the final placement of an inserted value.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pa;
    mem_wdata = mem_rdata;
    mem_raddr = ra;
    if (state == S_IDLE) begin
      if (acc && !full &&
          ((req.command == CMD_APPEND) ||
           ((req.command == CMD_INSERT) && (pos_in == cnt_ext)))) begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = req.element;
      end
    end else if ((state == S_RUN) || (state == S_TAIL)) begin
      mem_we = pv && (cmd != CMD_SEARCH);
    end else if (state == S_PUT) begin
      mem_we    = 1'b1;
      mem_waddr = pos[AW-1:0];
      mem_wdata = val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pv    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            cmd  <= req.command;
            val  <= req.element;
            pos  <= pos_in;
            err  <= 1'b0;
            hit  <= 1'b0;
            hidx <= '0;
            pv   <= 1'b0;
            unique case (req.command)
              CMD_APPEND: begin
                if (full) begin
                  err <= 1'b1;
                end else begin
                  cnt <= cnt + CW'(1);
                end
                state <= S_RESP;
              end
              CMD_INSERT: begin
                if ((pos_in > cnt_ext) || full) begin
                  err   <= 1'b1;
                  state <= S_RESP;
                end else if (pos_in == cnt_ext) begin
                  cnt   <= cnt + CW'(1);
                  state <= S_RESP;
                end else begin
                  ra    <= cnt_m1[AW-1:0];
                  state <= S_RUN;
                end
              end
              CMD_SEARCH: begin
                if (cnt == '0) begin
                  state <= S_RESP;
                end else begin
                  ra    <= '0;
                  state <= S_RUN;
                end
              end
              CMD_DELETE: begin
                if (pos_in >= cnt_ext) begin
                  err   <= 1'b1;
                  state <= S_RESP;
                end else if ((pos_in + POS_W'(1)) == cnt_ext) begin
                  cnt   <= cnt_m1;
                  state <= S_RESP;
                end else begin
                  ra    <= pos_in[AW-1:0] + AW'(1);
                  state <= S_RUN;
                end
              end
            endcase
          end
        end
        S_RUN: begin
          if (pv && (cmd == CMD_SEARCH) && match) begin
            hit   <= 1'b1;
            hidx  <= pa;
            pv    <= 1'b0;
            state <= S_RESP;
          end else begin
            pv <= 1'b1;
            pa <= pa_next;
            ra <= (cmd == CMD_INSERT) ? (ra - AW'(1)) : (ra + AW'(1));
            if (last_rd) begin
              state <= S_TAIL;
            end
          end
        end
        S_TAIL: begin
          pv <= 1'b0;
          if (cmd == CMD_SEARCH) begin
            if (match) begin
              hit  <= 1'b1;
              hidx <= pa;
            end
            state <= S_RESP;
          end else if (cmd == CMD_INSERT) begin
            state <= S_PUT;
          end else begin
            cnt   <= cnt_m1;
            state <= S_RESP;
          end
        end
        S_PUT: begin
          cnt   <= cnt + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign done            = (state == S_RESP) && slot_free;
  assign res.status      = err;
  assign res.found       = hit;
  assign res.found_index = IDX_W'(hidx);
  assign res.entry_count = cnt_ext;
  assign res.is_empty    = (cnt == '0);
  assign res.is_full     = full;

endmodule
